// ===== hdl/wcm_pkg.sv =====
package wcm_pkg;

  localparam int KEYS_DEF = 16384;
  localparam int KEY_W    = 15;
  localparam int WEIGHT_W = 32;
  localparam int VAL_W    = 48;

  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_QRD   = 7'b0000100,
    ST_URD   = 7'b0001000,
    ST_FOLD  = 7'b0010000,
    ST_SUM   = 7'b0100000,
    ST_WR    = 7'b1000000
  } state_t;

  typedef struct packed {
    logic clr;
    logic we;
    logic rd_u;
    logic cap_q;
    logic cap_u;
    logic fold;
  } cell_ctrl_t;

endpackage

// ===== hdl/wcm_in_if.sv =====
interface wcm_in_if import wcm_pkg::*;;
  logic                valid;
  logic                ready;
  logic [KEY_W-1:0]    key;
  logic [WEIGHT_W-1:0] weight;

  modport source (output valid, output key, output weight, input ready);
  modport sink   (input valid, input key, input weight, output ready);
endinterface

// ===== hdl/wcm_out_if.sv =====
interface wcm_out_if import wcm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] chain_value;
  logic [VAL_W-1:0] best_so_far;

  modport source (output valid, output chain_value, output best_so_far, input ready);
  modport sink   (input valid, input chain_value, input best_so_far, output ready);
endinterface

// ===== hdl/weighted_chain_max_dp_top.sv =====
// An accepted transaction steps through QRD, URD, FOLD, SUM and WR, which waits for a free
// output register, and then shows its result. LEVELS = clog2(KEYS) when KEYS > 2.
// One item at a time: ready only in IDLE; the max fold ripples one cell per cycle.
// Reset: synchronous; then a clearing pass zeroes every level memory,
// with the input not ready until it ends.
module weighted_chain_max_dp_top import wcm_pkg::*; #(
  parameter int KEYS = KEYS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  wcm_in_if.sink    item,
  wcm_out_if.source result
);

  localparam int LEVELS = (KEYS > 2) ? $clog2(KEYS) : 1;
  localparam int NCELL  = LEVELS + 1;
  localparam int CW     = $clog2(NCELL + 1);

  state_t            state;
  logic [LEVELS-1:0] clr_cnt;
  logic [LEVELS:0]   qcnt;
  logic [LEVELS-1:0] uleaf;
  logic [WEIGHT_W-1:0] weight;
  logic [CW-1:0]     fold_cnt;
  logic [VAL_W-1:0]  chain;
  logic [VAL_W-1:0]  best;
  logic              out_valid;
  logic [VAL_W-1:0]  out_chain;
  logic [VAL_W-1:0]  out_best;

  cell_ctrl_t        ctrl;
  logic [31:0]       key32;
  logic [31:0]       qc32;
  logic [31:0]       uk32;
  logic [31:0]       ul32;
  logic [VAL_W:0]    sum;
  logic [VAL_W-1:0]  chain_next;
  logic [VAL_W-1:0]  best_next;
  logic              wr_go;
  logic [VAL_W-1:0]  acc [NCELL+1];

  assign key32 = 32'(item.key);
  assign qc32  = (key32 > 32'(KEYS)) ? 32'(KEYS) : key32;
  assign uk32  = (key32 < 32'd1) ? 32'd1 : qc32;
  assign ul32  = uk32 - 32'd1;

  assign sum        = {1'b0, acc[NCELL]} + (VAL_W+1)'(weight);
  assign chain_next = sum[VAL_W] ? VAL_MAX : sum[VAL_W-1:0];
  assign best_next  = (best > chain) ? best : chain;
  assign wr_go      = (state == ST_WR) && (!out_valid || result.ready);

  assign item.ready = (state == ST_IDLE);

  always_comb begin
    ctrl       = '0;
    ctrl.clr   = (state == ST_CLEAR);
    ctrl.rd_u  = (state == ST_URD);
    ctrl.cap_q = (state == ST_URD);
    ctrl.fold  = (state == ST_FOLD);
    ctrl.cap_u = (state == ST_FOLD) && (fold_cnt == '0);
    ctrl.we    = wr_go;
  end

  assign acc[0] = '0;

  for (genvar l = 0; l < NCELL; l++) begin : g_cell
    wcm_cell #(.LEVELS(LEVELS), .LEVEL(l)) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .qcnt     (qcnt),
      .uleaf    (uleaf),
      .clr_addr (clr_cnt),
      .chain    (chain),
      .acc_in   (acc[l]),
      .acc_out  (acc[l+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      fold_cnt  <= '0;
      best      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready && !wr_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item.valid) begin
            qcnt   <= qc32[LEVELS:0];
            uleaf  <= ul32[LEVELS-1:0];
            weight <= item.weight;
            state  <= ST_QRD;
          end
        end
        ST_QRD: state <= ST_URD;
        ST_URD: begin
          fold_cnt <= '0;
          state    <= ST_FOLD;
        end
        ST_FOLD: begin
          fold_cnt <= fold_cnt + 1'b1;
          if (fold_cnt == CW'(NCELL - 1)) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          chain <= chain_next;
          state <= ST_WR;
        end
        ST_WR: begin
          // hold until the output register is free
          if (wr_go) begin
            best      <= best_next;
            out_chain <= chain;
            out_best  <= best_next;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  assign result.valid       = out_valid;
  assign result.chain_value = out_chain;
  assign result.best_so_far = out_best;

endmodule

// ===== hdl/wcm_ram.sv =====
module wcm_ram #(
  parameter int WIDTH  = 48,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/wcm_cell.sv =====
module wcm_cell import wcm_pkg::*; #(
  parameter int LEVELS = 14,
  parameter int LEVEL  = 0
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [LEVELS:0]   qcnt,
  input  logic [LEVELS-1:0] uleaf,
  input  logic [LEVELS-1:0] clr_addr,
  input  logic [VAL_W-1:0]  chain,
  input  logic [VAL_W-1:0]  acc_in,
  output logic [VAL_W-1:0]  acc_out
);

  localparam int AW = (LEVELS - LEVEL) > 0 ? (LEVELS - LEVEL) : 1;

  logic [31:0]      qshift;
  logic [31:0]      qnode;
  logic [31:0]      unode;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [VAL_W-1:0] rdata;
  logic [VAL_W-1:0] qdata;
  logic [VAL_W-1:0] udata;
  logic [VAL_W-1:0] acc;

  // prefix covers node (q>>level)-1 at this level when bit level of q is set
  assign qshift = 32'(qcnt) >> LEVEL;
  assign qnode  = qshift - 32'd1;
  assign unode  = 32'(uleaf) >> LEVEL;

  assign raddr = ctrl.rd_u ? unode[AW-1:0] : qnode[AW-1:0];
  assign waddr = ctrl.clr ? clr_addr[AW-1:0] : unode[AW-1:0];
  assign wdata = ctrl.clr ? '0 : ((udata > chain) ? udata : chain);

  wcm_ram #(.WIDTH(VAL_W), .ADDR_W(AW)) u_ram (
    .clk   (clk),
    .we    (ctrl.we | ctrl.clr),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (ctrl.cap_q) begin
      qdata <= qcnt[LEVEL] ? rdata : '0;
    end
    if (ctrl.cap_u) begin
      udata <= rdata;
    end
    if (ctrl.fold) begin
      acc <= (acc_in > qdata) ? acc_in : qdata;
    end
  end

  assign acc_out = acc;

endmodule

// ===== hdl/wcm_checker.sv =====
module wcm_checker import wcm_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VAL_W-1:0] chain_value,
  input logic [VAL_W-1:0] best_so_far
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chain_value) && $stable(best_so_far))
    else $error("stalled result transaction changed");

  a_best_ge: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> best_so_far >= chain_value)
    else $error("best below chain value");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while item in flight");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("block active right after reset");

endmodule

bind weighted_chain_max_dp_top wcm_checker u_wcm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .chain_value (result.chain_value),
  .best_so_far (result.best_so_far)
);
